FILE: design/hmds_pkg.sv
// ----------------------------------------------------------------------------
// hmds_pkg
// Shared constants for the masked 2x2 height map downsampler.
// ----------------------------------------------------------------------------
package hmds_pkg;

   // default geometry and sample width
   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int HEIGHT_BITS_DEF = 16;

   // width control register
   localparam int CFG_BITS = 11;
   localparam logic [CFG_BITS-1:0] SOURCE_WIDTH_RESET = CFG_BITS'(1024);

   // valid-sample count of one 2x2 block, 0..4
   localparam int CNT_BITS = 3;

endpackage

FILE: design/hmds_avg.sv
// ----------------------------------------------------------------------------
// hmds_avg
// Block averager: divides a 2x2 block sum by its valid count (1..4),
// truncating toward zero, zero for a count of 0. Three register stages with a stall chain.
// ----------------------------------------------------------------------------
module hmds_avg
   import hmds_pkg::*;
#(
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [HEIGHT_BITS+1:0] in_sum,
   input  logic [CNT_BITS-1:0]           in_cnt,
   input  logic                          in_last,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [HEIGHT_BITS-1:0]        out_avg,
   output logic                          out_nonzero,
   output logic                          out_last
);

   localparam int BW  = HEIGHT_BITS + 2;
   localparam int K   = BW;
   localparam int PRW = BW + K;
   localparam int RW  = BW + 2;
   localparam logic [K-1:0] RECIP3 = K'((64'd1 << K) / 64'd3);

   // stage 1: block sum and count
   logic                   s1_valid_ff, s1_valid_in;
   logic signed [BW-1:0]   s1_sum_ff;
   logic [CNT_BITS-1:0]    s1_cnt_ff;
   logic                   s1_last_ff;

   // stage 2: magnitude and estimated third
   logic                   s2_valid_ff, s2_valid_in;
   logic [BW-1:0]          s2_mag_ff, s2_mag_in;
   logic [BW-1:0]          s2_q0_ff, s2_q0_in;
   logic                   s2_neg_ff, s2_neg_in;
   logic [CNT_BITS-1:0]    s2_cnt_ff;
   logic                   s2_last_ff;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [HEIGHT_BITS-1:0] out_avg_ff, out_avg_in;
   logic                   out_nz_ff, out_nz_in;
   logic                   out_last_ff;

   logic                   out_free, s2_free, s1_free;
   logic [PRW-1:0]         s1_prod;
   logic [RW-1:0]          three_q, rem;
   logic [BW-1:0]          q3, quot;

   // stall chain
   assign out_free = !out_valid_ff || out_ready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_ready = s1_free;

   assign s1_valid_in  = s1_free  ? in_valid    : s1_valid_ff;
   assign s2_valid_in  = s2_free  ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_free ? s2_valid_ff : out_valid_ff;

   // magnitude and reciprocal multiply by one third
   always_comb begin
      s2_neg_in = s1_sum_ff[BW-1];
      s2_mag_in = s2_neg_in ? BW'(-s1_sum_ff) : BW'(s1_sum_ff);
      s1_prod   = PRW'(s2_mag_in) * PRW'(RECIP3);
      s2_q0_in  = s1_prod[PRW-1:K];
   end

   // correct the third and pick the quotient by count
   always_comb begin
      three_q = RW'({s2_q0_ff, 1'b0}) + RW'(s2_q0_ff);
      rem     = RW'(s2_mag_ff) - three_q;
      q3      = (rem >= RW'(3)) ? s2_q0_ff + BW'(1) : s2_q0_ff;
      case (s2_cnt_ff)
         CNT_BITS'(1): quot = s2_mag_ff;
         CNT_BITS'(2): quot = s2_mag_ff >> 1;
         CNT_BITS'(3): quot = q3;
         CNT_BITS'(4): quot = s2_mag_ff >> 2;
         default:      quot = '0;
      endcase
      out_avg_in = HEIGHT_BITS'(s2_neg_ff ? (BW'(0) - quot) : quot);
      out_nz_in  = (s2_cnt_ff != '0);
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_free && in_valid) begin
         s1_sum_ff  <= in_sum;
         s1_cnt_ff  <= in_cnt;
         s1_last_ff <= in_last;
      end
      if (s2_free && s1_valid_ff) begin
         s2_mag_ff  <= s2_mag_in;
         s2_q0_ff   <= s2_q0_in;
         s2_neg_ff  <= s2_neg_in;
         s2_cnt_ff  <= s1_cnt_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (out_free && s2_valid_ff) begin
         out_avg_ff  <= out_avg_in;
         out_nz_ff   <= out_nz_in;
         out_last_ff <= s2_last_ff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_avg     = out_avg_ff;
   assign out_nonzero = out_nz_ff;
   assign out_last    = out_last_ff;

endmodule

FILE: design/heightmap_masked_downsample_2x2.sv
// ----------------------------------------------------------------------------
// heightmap_masked_downsample_2x2
// Halves a square height map by averaging the valid samples of each 2x2 block.
// ----------------------------------------------------------------------------
// Samples enter in raster order, one beat each, with tuser marking a real
// height; the map is csr_wdata samples wide and high (bit 0 ignored, clamped
// to 2..MAX_WIDTH), and writing the width restarts the map at the next beat.
// Each 2x2 block gives one result on its bottom-right sample: the average of
// its valid heights truncated toward zero, tuser low and data zero when none
// is valid, tlast on the final block of the map. The block accepts one sample
// per clock and keeps that rate unless held results stall it, since the
// single-port line store of MAX_WIDTH/2 entries is touched at most once per
// sample pair (written on even rows, read on odd rows). A result passes
// through three result registers; a held result stalls the input only once
// all three are full. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
module heightmap_masked_downsample_2x2
   import hmds_pkg::*;
#(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
   localparam int TDW        = ((HEIGHT_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CFG_BITS-1:0] csr_wdata,   // source_width
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TDW-1:0]      req_tdata,   // height
   input  logic                req_tuser,   // height_valid
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDW-1:0]      rsp_tdata,   // avg_height
   output logic                rsp_tuser,   // avg_valid
   output logic                rsp_tlast    // last
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LW         = $clog2(LINE_DEPTH);
   localparam int EW         = (CFG_BITS > CW + 1) ? CFG_BITS : CW + 1;
   localparam int PW         = HEIGHT_BITS + 1;
   localparam int BW         = HEIGHT_BITS + 2;
   localparam int EN         = PW + 2;
   localparam logic [EW-1:0] W_MAX = EW'(MAX_WIDTH - (MAX_WIDTH % 2));

   logic [CFG_BITS-1:0]    src_width_ff;
   logic [CW-1:0]          col_ff, col_in, row_ff, row_in;
   logic [HEIGHT_BITS-1:0] acc_h_ff, acc_h_in;
   logic                   acc_v_ff, acc_v_in;

   logic [EN-1:0]          line_mem [LINE_DEPTH];
   logic [EN-1:0]          rd_data_ff;

   logic [EW-1:0]          w_even, w_eff;
   logic                   accept, col_end, row_end;
   logic [HEIGHT_BITS-1:0] height;
   logic                   height_valid;
   logic signed [PW-1:0]   acc_term, cur_term, pair_sum, rd_sum;
   logic [1:0]             pair_cnt, rd_cnt;
   logic [LW-1:0]          line_idx;
   logic                   wr_en, rd_en;
   logic signed [BW-1:0]   blk_sum;
   logic [CNT_BITS-1:0]    blk_cnt;
   logic                   blk_valid, blk_ready, blk_last;
   logic [HEIGHT_BITS-1:0] avg_height;

   assign height       = req_tdata[HEIGHT_BITS-1:0];
   assign height_valid = req_tuser;
   assign accept       = req_tvalid && req_tready;

   // effective width: even, clamped to the line store
   always_comb begin
      w_even = EW'(src_width_ff) & ~EW'(1);
      if (w_even < EW'(2)) begin
         w_eff = EW'(2);
      end else if (w_even > W_MAX) begin
         w_eff = W_MAX;
      end else begin
         w_eff = w_even;
      end
   end

   assign col_end = (EW'(col_ff) + EW'(1)) >= w_eff;
   assign row_end = (EW'(row_ff) + EW'(1)) >= w_eff;

   // raster position and first sample of the pair
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      acc_h_in = acc_h_ff;
      acc_v_in = acc_v_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
         if (!col_ff[0]) begin
            acc_h_in = height;
            acc_v_in = height_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff <= SOURCE_WIDTH_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         acc_h_ff     <= '0;
         acc_v_ff     <= 1'b0;
      end else if (csr_we) begin
         src_width_ff <= csr_wdata;
         col_ff       <= '0;
         row_ff       <= '0;
         acc_h_ff     <= '0;
         acc_v_ff     <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         acc_h_ff     <= acc_h_in;
         acc_v_ff     <= acc_v_in;
      end
   end

   // horizontal pair sum and count
   assign acc_term = acc_v_ff ? PW'(signed'(acc_h_ff)) : '0;
   assign cur_term = height_valid ? PW'(signed'(height)) : '0;
   assign pair_sum = acc_term + cur_term;
   assign pair_cnt = 2'(acc_v_ff) + 2'(height_valid);

   // line store: write pairs on even rows, fetch them on odd rows
   assign line_idx = LW'(col_ff >> 1);
   assign wr_en    = accept && !row_ff[0] && col_ff[0];
   assign rd_en    = accept && row_ff[0] && !col_ff[0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[line_idx] <= {pair_cnt, pair_sum};
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[line_idx];
      end
   end

   assign rd_sum = rd_data_ff[PW-1:0];
   assign rd_cnt = rd_data_ff[EN-1:PW];

   // full block on the odd column of an odd row
   assign blk_valid = req_tvalid && row_ff[0] && col_ff[0];
   assign blk_sum   = BW'(pair_sum) + BW'(rd_sum);
   assign blk_cnt   = CNT_BITS'(pair_cnt) + CNT_BITS'(rd_cnt);
   assign blk_last  = col_end && row_end;

   assign req_tready = blk_ready;

   hmds_avg #(
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_avg (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (blk_valid),
      .in_ready    (blk_ready),
      .in_sum      (blk_sum),
      .in_cnt      (blk_cnt),
      .in_last     (blk_last),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_avg     (avg_height),
      .out_nonzero (rsp_tuser),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = TDW'(avg_height);

endmodule

FILE: design/hmds_check.sv
// ----------------------------------------------------------------------------
// hmds_check
// Port-level checks for the 2x2 height map downsampler, bound to the top.
// ----------------------------------------------------------------------------
module hmds_check
   import hmds_pkg::*;
#(
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
   localparam int TDW        = ((HEIGHT_BITS + 7) / 8) * 8
) (
   input logic           clock,
   input logic           reset,
   input logic           rsp_tvalid,
   input logic           rsp_tready,
   input logic [TDW-1:0] rsp_tdata,
   input logic           rsp_tuser,
   input logic           rsp_tlast
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // a block with no valid sample reports zero height
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("invalid block carries nonzero height");

   // the pipeline comes out of reset empty
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present right after reset");

   // a result rises only once reset has been low long enough for a sample to pass the result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(reset, 1) && !$past(reset, 2))
      else $error("result appeared too soon after reset");

endmodule

bind heightmap_masked_downsample_2x2 hmds_check #(
   .HEIGHT_BITS (HEIGHT_BITS)
) u_hmds_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
